// ----- hw/rtl/dpg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dashed polyline generator package
// Shared widths, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package dpg_pkg;

	localparam int COORD_W    = 32;              // coordinate width, Q16.16
	localparam int REG_W      = 31;              // dash and gap registers
	localparam int MAG_W      = COORD_W + 1;     // magnitude of a coordinate delta
	localparam int LEN_W      = COORD_W + 1;     // segment length
	localparam int SQ_W       = 2 * MAG_W;       // sum of squares, product width
	localparam int PHASE_W    = COORD_W + 2;     // carried dash phase
	localparam int T_W        = COORD_W + 3;     // walk position along a segment
	localparam int MAX_DASHES = 64;              // dashes per segment
	localparam int K_W        = $clog2(MAX_DASHES + 1);
	localparam int CNT_W      = $clog2(LEN_W + 1);

	typedef logic [0:0] reg_idx_t;
	localparam reg_idx_t REG_DASH = 1'b0;
	localparam reg_idx_t REG_GAP  = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ,
		ST_SQRT_GO,
		ST_SQRT_WAIT,
		ST_CHECK,
		ST_IMUL,
		ST_IDIV_GO,
		ST_IDIV_WAIT,
		ST_EMIT,
		ST_CAP_WAIT
	} state_t;

endpackage

// ----- hw/rtl/dpg_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative integer square root
// Restoring digit-by-digit square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module dpg_sqrt import dpg_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SQ_W-1:0]  radicand,
	output logic             done,
	output logic [LEN_W-1:0] root
);

	logic [SQ_W-1:0]  rad_q;
	logic [LEN_W+2:0] rem_q;
	logic [LEN_W-1:0] root_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [LEN_W+2:0] shifted;
	logic [LEN_W+2:0] trial;
	logic             fits;

	assign shifted = {rem_q[LEN_W:0], rad_q[SQ_W-1 -: 2]};
	assign trial   = {1'b0, root_q, 2'b01};
	assign fits    = shifted >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(LEN_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[SQ_W-3:0], 2'b00};
			rem_q  <= fits ? shifted - trial : shifted;
			root_q <= {root_q[LEN_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ----- hw/rtl/dpg_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring division, one quotient bit per cycle. The upper half of the
// dividend must be below the divisor, so the quotient fits in LEN_W bits.
// ----------------------------------------------------------------------------
module dpg_div import dpg_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SQ_W-1:0]  dividend,
	input  logic [LEN_W-1:0] divisor,
	output logic             done,
	output logic [LEN_W-1:0] quot,
	output logic [LEN_W-1:0] rem
);

	logic [LEN_W-1:0] rem_q;
	logic [LEN_W-1:0] low_q;
	logic [LEN_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [LEN_W:0]   shifted;
	logic             fits;
	logic [LEN_W:0]   diff;

	assign shifted = {rem_q, low_q[LEN_W-1]};
	assign fits    = shifted >= {1'b0, dvs_q};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(LEN_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[SQ_W-1 -: LEN_W];
			low_q <= dividend[LEN_W-1:0];
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[LEN_W-1:0] : shifted[LEN_W-1:0];
			low_q <= {low_q[LEN_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = low_q;
	assign rem  = rem_q;

endmodule

// ----- hw/rtl/dashed_polyline_generator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dashed polyline generator
// Walks a dash pattern along a 3D polyline and emits one beat per dash.
// ----------------------------------------------------------------------------
// Vertices enter one beat at a time on the vtx channel; a beat with
// path_start set (or the first beat after reset) only stores the point. Each
// further vertex closes a segment: the block takes the integer length of the
// segment, rounded down by the square root, and emits, on the dash channel,
// every dash that fits wholly inside it, at most 64 per segment, with
// last_dash marking the final one for that vertex. For the length, the
// block squares the deltas on the shared multiplier, starts the serial square
// root and waits for it; then, for each emitted dash, each of the six
// coordinates takes a multiply step, a divider start step and the serial
// divide, plus one check and one load step per dash. When the dash cap is
// hit, one more divide advances the phase by a remainder. A dash beat that is
// still stalled in the output register holds the sequencer in its load step
// until it moves. vtx_stall is low only when the block is idle; the dash
// output register lets the last beat wait while the next vertex is taken.
// dash_len and gap_len sit at APB byte addresses 0 and 4.
// ----------------------------------------------------------------------------
module dashed_polyline_generator import dpg_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	// APB configuration port
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [2:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	// vertex channel
	input  logic                      vtx_valid,
	output logic                      vtx_stall,
	input  logic signed [COORD_W-1:0] px,
	input  logic signed [COORD_W-1:0] py,
	input  logic signed [COORD_W-1:0] pz,
	input  logic                      path_start,
	// dash channel
	output logic                      dash_valid,
	input  logic                      dash_stall,
	output logic signed [COORD_W-1:0] sx,
	output logic signed [COORD_W-1:0] sy,
	output logic signed [COORD_W-1:0] sz,
	output logic signed [COORD_W-1:0] ex,
	output logic signed [COORD_W-1:0] ey,
	output logic signed [COORD_W-1:0] ez,
	output logic                      last_dash
);

	// Configuration registers.
	logic [REG_W-1:0] dash_q;
	logic [REG_W-1:0] gap_q;
	reg_idx_t         cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dash_q <= REG_W'(655360);
			gap_q  <= REG_W'(327680);
		end else if (psel && penable && pwrite) begin
			case (cfg_idx)
				REG_DASH: dash_q <= pwdata[REG_W-1:0];
				REG_GAP:  gap_q  <= pwdata[REG_W-1:0];
				default:  dash_q <= dash_q;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_DASH: prdata = {1'b0, dash_q};
			REG_GAP:  prdata = {1'b0, gap_q};
			default:  prdata = '0;
		endcase
	end

	// Sequencer and path state.
	state_t state_q, state_d;

	logic [COORD_W-1:0] prev_q [3];
	logic [COORD_W-1:0] cur_q  [3];
	logic [MAG_W-1:0]   mag_q  [3];
	logic [2:0]         neg_q;
	logic               have_prev_q;
	logic [PHASE_W-1:0] phase_q;
	logic [SQ_W-1:0]    acc_q;
	logic [SQ_W-1:0]    prod_q;
	logic [2:0]         cnt_q;
	logic [LEN_W-1:0]   len_q;
	logic [T_W-1:0]     t_q;
	logic [K_W-1:0]     k_q;
	logic [2:0]         j_q;
	logic [COORD_W-1:0] res_q  [6];
	logic [COORD_W-1:0] out_q  [6];
	logic               last_q;
	logic               out_valid_q;

	logic vtx_acc;
	logic out_load;
	logic sqrt_start, div_start;
	logic sqrt_done, div_done;
	logic [LEN_W-1:0] sqrt_root, div_quot, div_rem;

	assign vtx_acc  = vtx_valid && !vtx_stall;
	assign out_load = (state_q == ST_EMIT) && (!out_valid_q || !dash_stall);

	// Walk conditions at the current position.
	logic [T_W-1:0]   len_ext;
	logic [T_W-1:0]   dash_ext;
	logic [T_W-1:0]   per;
	logic [T_W-1:0]   t_end;
	logic [T_W-1:0]   t_next;
	logic [T_W-1:0]   t_next_end;
	logic             t_past, dash_over, cap_hit, per_zero, more;

	assign len_ext    = T_W'(len_q);
	assign dash_ext   = T_W'(dash_q);
	assign per        = T_W'(dash_q) + T_W'(gap_q);
	assign t_end      = t_q + dash_ext;
	assign t_next     = t_q + per;
	assign t_next_end = t_next + dash_ext;
	assign t_past     = t_q >= len_ext;
	assign dash_over  = t_end > len_ext;
	assign cap_hit    = k_q == K_W'(MAX_DASHES);
	assign per_zero   = per == '0;
	assign more       = (t_next < len_ext) && (t_next_end <= len_ext)
	                    && (k_q + 1'b1 < K_W'(MAX_DASHES));

	// Axis and operand selection for the shared multiplier.
	logic [1:0]       axis;
	logic [MAG_W-1:0] mul_a;
	logic [MAG_W-1:0] mul_b;
	logic [SQ_W-1:0]  mul_p;

	always_comb begin
		if (state_q == ST_SQ)
			axis = cnt_q[1:0];
		else if (j_q < 3'd3)
			axis = j_q[1:0];
		else
			axis = 2'(j_q - 3'd3);
	end

	always_comb begin
		case (axis)
			2'd0:    mul_a = mag_q[0];
			2'd1:    mul_a = mag_q[1];
			2'd2:    mul_a = mag_q[2];
			default: mul_a = '0;
		endcase
		if (state_q == ST_SQ)
			mul_b = mul_a;
		else if (j_q < 3'd3)
			mul_b = t_q[MAG_W-1:0];
		else
			mul_b = t_end[MAG_W-1:0];
	end

	assign mul_p = mul_a * mul_b;

	// Rounded interpolation result for the coordinate under work.
	logic [LEN_W:0]     rem2;
	logic [LEN_W-1:0]   q_rnd;
	logic [COORD_W-1:0] base_c;
	logic               neg_c;
	logic [COORD_W-1:0] coord;

	assign rem2  = {div_rem, 1'b0};
	assign q_rnd = div_quot + LEN_W'(rem2 >= {1'b0, len_q});

	always_comb begin
		case (axis)
			2'd0:    begin base_c = prev_q[0]; neg_c = neg_q[0]; end
			2'd1:    begin base_c = prev_q[1]; neg_c = neg_q[1]; end
			2'd2:    begin base_c = prev_q[2]; neg_c = neg_q[2]; end
			default: begin base_c = '0; neg_c = 1'b0; end
		endcase
	end

	assign coord = neg_c ? base_c - q_rnd[COORD_W-1:0] : base_c + q_rnd[COORD_W-1:0];

	// Cap handling: the phase follows from the remainder of the rest of the
	// segment by the period, without walking the dropped dashes.
	logic [T_W-1:0]  cap_base;
	logic [T_W-1:0]  cap_num;
	logic [T_W-1:0]  cap_t;
	logic [T_W-1:0]  cap_tn;
	logic [SQ_W-1:0] div_dvd;
	logic [LEN_W-1:0] div_dvs;

	assign cap_base = (dash_q == '0) ? len_ext - T_W'(1) : len_ext - dash_ext;
	assign cap_num  = cap_base - t_q;
	assign cap_t    = cap_base - T_W'(div_rem) + per;
	assign cap_tn   = (cap_t < len_ext) ? cap_t + dash_ext : cap_t;
	assign div_dvd  = (state_q == ST_CHECK) ? SQ_W'(cap_num) : prod_q;
	assign div_dvs  = (state_q == ST_CHECK) ? per[LEN_W-1:0] : len_q;

	// Vertex deltas.
	logic [COORD_W:0] delta [3];
	assign delta[0] = {px[COORD_W-1], px} - {prev_q[0][COORD_W-1], prev_q[0]};
	assign delta[1] = {py[COORD_W-1], py} - {prev_q[1][COORD_W-1], prev_q[1]};
	assign delta[2] = {pz[COORD_W-1], pz} - {prev_q[2][COORD_W-1], prev_q[2]};

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:
				if (vtx_acc && !path_start && have_prev_q)
					state_d = ST_SQ;
			ST_SQ:
				if (cnt_q == 3'd3)
					state_d = ST_SQRT_GO;
			ST_SQRT_GO:
				state_d = ST_SQRT_WAIT;
			ST_SQRT_WAIT:
				if (sqrt_done)
					state_d = (sqrt_root == '0) ? ST_IDLE : ST_CHECK;
			ST_CHECK:
				if (t_past || dash_over)
					state_d = ST_IDLE;
				else if (!cap_hit)
					state_d = ST_IMUL;
				else if (per_zero)
					state_d = ST_IDLE;
				else
					state_d = ST_CAP_WAIT;
			ST_IMUL:
				state_d = ST_IDIV_GO;
			ST_IDIV_GO:
				state_d = ST_IDIV_WAIT;
			ST_IDIV_WAIT:
				if (div_done)
					state_d = (j_q == 3'd5) ? ST_EMIT : ST_IMUL;
			ST_EMIT:
				if (out_load)
					state_d = ST_CHECK;
			ST_CAP_WAIT:
				if (div_done)
					state_d = ST_IDLE;
			default:
				state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		vtx_stall  = 1'b1;
		sqrt_start = 1'b0;
		div_start  = 1'b0;
		case (state_q)
			ST_IDLE:    vtx_stall  = 1'b0;
			ST_SQRT_GO: sqrt_start = 1'b1;
			ST_IDIV_GO: div_start  = 1'b1;
			ST_CHECK:   div_start  = !t_past && !dash_over && cap_hit && !per_zero;
			default:    vtx_stall  = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			have_prev_q <= 1'b0;
			phase_q     <= '0;
			prev_q[0]   <= '0;
			prev_q[1]   <= '0;
			prev_q[2]   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (out_load)
				out_valid_q <= 1'b1;
			else if (!dash_stall)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE:
					if (vtx_acc && (path_start || !have_prev_q)) begin
						prev_q[0]   <= px;
						prev_q[1]   <= py;
						prev_q[2]   <= pz;
						have_prev_q <= 1'b1;
						if (path_start)
							phase_q <= '0;
					end
				ST_SQRT_WAIT:
					if (sqrt_done && sqrt_root == '0)
						prev_q <= cur_q;
				ST_CHECK:
					if (t_past) begin
						phase_q <= PHASE_W'(t_q - len_ext);
						prev_q  <= cur_q;
					end else if (dash_over) begin
						phase_q <= PHASE_W'(t_end - len_ext);
						prev_q  <= cur_q;
					end else if (cap_hit && per_zero) begin
						phase_q <= '0;
						prev_q  <= cur_q;
					end
				ST_CAP_WAIT:
					if (div_done) begin
						phase_q <= PHASE_W'(cap_tn - len_ext);
						prev_q  <= cur_q;
					end
				default:
					have_prev_q <= have_prev_q;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE:
				if (vtx_acc) begin
					cur_q[0] <= px;
					cur_q[1] <= py;
					cur_q[2] <= pz;
					for (int i = 0; i < 3; i++) begin
						neg_q[i] <= delta[i][COORD_W];
						mag_q[i] <= delta[i][COORD_W] ? MAG_W'(-delta[i]) : MAG_W'(delta[i]);
					end
					acc_q <= '0;
					cnt_q <= '0;
				end
			ST_SQ: begin
				if (cnt_q != 3'd3)
					prod_q <= mul_p;
				if (cnt_q != 3'd0)
					acc_q <= acc_q + prod_q;
				cnt_q <= cnt_q + 1'b1;
			end
			ST_SQRT_WAIT:
				if (sqrt_done) begin
					len_q <= sqrt_root;
					t_q   <= T_W'(phase_q);
					k_q   <= '0;
				end
			ST_CHECK:
				j_q <= '0;
			ST_IMUL:
				prod_q <= mul_p;
			ST_IDIV_WAIT:
				if (div_done) begin
					res_q[j_q] <= coord;
					j_q        <= j_q + 1'b1;
					if (j_q == 3'd5) begin
						t_q    <= t_next;
						k_q    <= k_q + 1'b1;
						last_q <= !more;
					end
				end
			ST_EMIT:
				if (out_load) begin
					out_q     <= res_q;
					last_dash <= last_q;
				end
			default:
				cnt_q <= cnt_q;
		endcase
	end

	dpg_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (acc_q),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	dpg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	assign dash_valid = out_valid_q;
	assign sx = out_q[0];
	assign sy = out_q[1];
	assign sz = out_q[2];
	assign ex = out_q[3];
	assign ey = out_q[4];
	assign ez = out_q[5];

	// The dash count never passes the cap.
	a_k_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IMUL) |-> (k_q < K_W'(MAX_DASHES)))
		else $error("dash count at cap while interpolating");

	// Interpolation only runs on a nonzero length with the start inside it.
	a_interp_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IMUL) |-> (len_q != '0 && t_q < len_ext))
		else $error("interpolation outside segment");

	// A segment is only worked on when a previous vertex is held.
	a_have_prev: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> have_prev_q)
		else $error("segment without previous vertex");

	// An emitted dash is loaded only after all six coordinates are done.
	a_emit_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && $past(state_q) != ST_EMIT) |-> ($past(j_q) == 3'd5))
		else $error("dash loaded before coordinates complete");

endmodule
